// File: sv/iee_pkg.sv
// Shared types, codes and helpers for the infix expression evaluator.
package iee_pkg;

   localparam int unsigned STACK_DEPTH_DEFAULT = 16;
   localparam int unsigned DATA_W = 32;
   localparam int unsigned OPC_W = 3;
   localparam int unsigned ERR_W = 2;

   localparam logic [OPC_W-1:0] OPC_OTHER = 3'd0;
   localparam logic [OPC_W-1:0] OPC_ADD   = 3'd1;
   localparam logic [OPC_W-1:0] OPC_SUB   = 3'd2;
   localparam logic [OPC_W-1:0] OPC_MUL   = 3'd3;
   localparam logic [OPC_W-1:0] OPC_DIV   = 3'd4;

   localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
   localparam logic [ERR_W-1:0] ERR_DIVZERO   = 2'd1;
   localparam logic [ERR_W-1:0] ERR_UNDERFLOW = 2'd2;
   localparam logic [ERR_W-1:0] ERR_OVERFLOW  = 2'd3;

   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   // controller -> datapath commands
   typedef struct packed {
      logic             load_req;     // capture request symbol
      logic             push_digit;   // push digit operand (with overflow check)
      logic             push_op;      // push captured operator
      logic             pop_op;       // pop operator into working register
      logic             fetch;        // read top two operands
      logic             fetch_top;    // unused; the top operand is read at the default address
      logic             start_alu;    // start arithmetic on fetched operands
      logic             push_result;  // pop two operands, push result
      logic             underflow;    // record underflow
      logic             emit;         // load response registers
      logic             clear;        // clear stacks and error
   } iee_cmd_type;

   // datapath -> controller status
   typedef struct packed {
      logic             is_digit;
      logic             ops_empty;
      logic             top_prio_ge;  // stacked top priority >= incoming
      logic             two_operands;
      logic             any_operand;
      logic             alu_done;
   } iee_sts_type;

   function automatic logic [OPC_W-1:0] code_of(input logic [7:0] ch);
      logic [OPC_W-1:0] c;
      case (ch)
         CH_PLUS:  c = OPC_ADD;
         CH_MINUS: c = OPC_SUB;
         CH_STAR:  c = OPC_MUL;
         CH_SLASH: c = OPC_DIV;
         default:  c = OPC_OTHER;
      endcase
      return c;
   endfunction

   function automatic logic [1:0] prio_of(input logic [OPC_W-1:0] c);
      logic [1:0] p;
      case (c)
         OPC_ADD, OPC_SUB: p = 2'd1;
         OPC_MUL, OPC_DIV: p = 2'd2;
         default:          p = 2'd0;
      endcase
      return p;
   endfunction

endpackage

// File: sv/iee_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
module iee_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: sv/iee_div.sv
// Iterative 32-bit signed divider, truncating, one quotient bit per cycle.
module iee_div
   import iee_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DATA_W-1:0] dividend,
   input  logic [DATA_W-1:0] divisor,
   output logic              done,
   output logic [DATA_W-1:0] quotient
);
   localparam int unsigned CNT_W = $clog2(DATA_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] dvs_ff, dvs_in;
   logic              neg_ff, neg_in;
   logic [DATA_W:0]   trial;
   logic [DATA_W:0]   shifted;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      shifted = {rem_ff, quo_ff[DATA_W-1]};
      trial   = shifted - {1'b0, dvs_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DATA_W);
         rem_in  = '0;
         quo_in  = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
         dvs_in  = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
         neg_in  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
      end else if (busy_ff) begin
         if (!trial[DATA_W]) begin
            rem_in = trial[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (~quo_ff + 1'b1) : quo_ff;
endmodule

// File: sv/iee_datapath.sv
// Datapath: two stacks in RAM, counters, sticky error, ALU and response registers.
module iee_datapath
   import iee_pkg::*;
#(
   parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  iee_cmd_type       cmd,
   output iee_sts_type       sts,
   input  logic [7:0]        req_symbol,
   output logic [DATA_W-1:0] out_value,
   output logic [ERR_W-1:0]  out_error
);
   localparam int unsigned AW = $clog2(STACK_DEPTH);
   localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

   logic [7:0]        sym_ff, sym_in;
   logic [CW-1:0]     opnd_cnt_ff, opnd_cnt_in;
   logic [CW-1:0]     oper_cnt_ff, oper_cnt_in;
   logic [ERR_W-1:0]  err_ff, err_in;
   logic [OPC_W-1:0]  op_ff, op_in;
   logic [DATA_W-1:0] a_ff, a_in;
   logic [DATA_W-1:0] res_ff, res_in;
   logic [DATA_W-1:0] val_ff, val_in;
   logic [ERR_W-1:0]  verr_ff, verr_in;
   logic [1:0]        ph_ff, ph_in;      // operand fetch phase
   logic              div_go_ff, div_go_in;
   logic              fin_ff, fin_in;

   logic              d_we, o_we;
   logic [AW-1:0]     d_wa, d_ra, o_wa, o_ra;
   logic [DATA_W-1:0] d_wd, d_rd;
   logic [OPC_W-1:0]  o_wd, o_rd;
   logic              div_done;
   logic [DATA_W-1:0] div_q;
   logic [OPC_W-1:0]  in_code;
   logic [DATA_W-1:0] mul_p;

   iee_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_opnd (
      .clock, .wr_en(d_we), .wr_addr(d_wa), .wr_data(d_wd), .rd_addr(d_ra), .rd_data(d_rd));
   iee_ram #(.WIDTH(OPC_W), .DEPTH(STACK_DEPTH)) u_oper (
      .clock, .wr_en(o_we), .wr_addr(o_wa), .wr_data(o_wd), .rd_addr(o_ra), .rd_data(o_rd));

   iee_div u_div (
      .clock, .reset, .start(div_go_ff), .dividend(a_ff), .divisor(d_rd),
      .done(div_done), .quotient(div_q));

   assign in_code = code_of(sym_ff);
   assign mul_p   = a_ff * d_rd;

   // operator RAM read address always tracks the top entry
   assign o_ra = AW'(oper_cnt_ff - 1'b1);

   always_comb begin
      sym_in      = cmd.load_req ? req_symbol : sym_ff;
      opnd_cnt_in = opnd_cnt_ff;
      oper_cnt_in = oper_cnt_ff;
      err_in      = err_ff;
      op_in       = op_ff;
      a_in        = a_ff;
      res_in      = res_ff;
      val_in      = val_ff;
      verr_in     = verr_ff;
      ph_in       = 2'd0;
      div_go_in   = 1'b0;
      fin_in      = 1'b0;
      d_we = 1'b0;  d_wa = AW'(opnd_cnt_ff);  d_wd = '0;
      o_we = 1'b0;  o_wa = AW'(oper_cnt_ff);  o_wd = in_code;
      d_ra = AW'(opnd_cnt_ff - 1'b1);

      if (cmd.push_digit) begin
         if (opnd_cnt_ff >= CW'(STACK_DEPTH)) begin
            if (err_ff == ERR_NONE) err_in = ERR_OVERFLOW;
         end else begin
            d_we = 1'b1;
            d_wd = DATA_W'(sym_ff - CH_ZERO);
            opnd_cnt_in = opnd_cnt_ff + 1'b1;
         end
      end
      if (cmd.push_op) begin
         if (oper_cnt_ff >= CW'(STACK_DEPTH)) begin
            if (err_ff == ERR_NONE) err_in = ERR_OVERFLOW;
         end else begin
            o_we = 1'b1;
            oper_cnt_in = oper_cnt_ff + 1'b1;
         end
      end
      if (cmd.pop_op) begin
         op_in = o_rd;
         oper_cnt_in = oper_cnt_ff - 1'b1;
      end
      if (cmd.underflow) begin
         if (err_ff == ERR_NONE) err_in = ERR_UNDERFLOW;
      end
      // fetch reads a (second from top); the following phase latches a and reads b
      if (cmd.fetch) begin
         d_ra  = AW'(opnd_cnt_ff - 2'd2);
         ph_in = 2'd1;
      end
      if (ph_ff == 2'd1) begin
         a_in  = d_rd;
         ph_in = 2'd2;
      end
      if (cmd.start_alu) begin
         // d_rd now holds b
         case (op_ff)
            OPC_ADD: begin res_in = a_ff + d_rd; fin_in = 1'b1; end
            OPC_SUB: begin res_in = a_ff - d_rd; fin_in = 1'b1; end
            OPC_MUL: begin res_in = mul_p;       fin_in = 1'b1; end
            OPC_DIV: begin
               if (d_rd == '0) begin
                  res_in = '0;
                  fin_in = 1'b1;
                  if (err_ff == ERR_NONE) err_in = ERR_DIVZERO;
               end else begin
                  div_go_in = 1'b1;
               end
            end
            default: begin res_in = '0; fin_in = 1'b1; end
         endcase
      end
      if (div_done) begin
         res_in = div_q;
         fin_in = 1'b1;
      end
      // stack had >= 2, so the result always fits
      if (cmd.push_result) begin
         d_we = 1'b1;
         d_wa = AW'(opnd_cnt_ff - 2'd2);
         d_wd = res_ff;
         opnd_cnt_in = opnd_cnt_ff - 1'b1;
      end
      if (cmd.emit) begin
         if (opnd_cnt_ff == '0) begin
            val_in  = '0;
            verr_in = (err_ff == ERR_NONE) ? ERR_UNDERFLOW : err_ff;
         end else begin
            val_in  = d_rd;
            verr_in = err_ff;
         end
      end
      if (cmd.clear) begin
         opnd_cnt_in = '0;
         oper_cnt_in = '0;
         err_in      = ERR_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         opnd_cnt_ff <= '0;
         oper_cnt_ff <= '0;
         err_ff      <= ERR_NONE;
         ph_ff       <= 2'd0;
         div_go_ff   <= 1'b0;
         fin_ff      <= 1'b0;
      end else begin
         opnd_cnt_ff <= opnd_cnt_in;
         oper_cnt_ff <= oper_cnt_in;
         err_ff      <= err_in;
         ph_ff       <= ph_in;
         div_go_ff   <= div_go_in;
         fin_ff      <= fin_in;
      end
      sym_ff  <= sym_in;
      op_ff   <= op_in;
      a_ff    <= a_in;
      res_ff  <= res_in;
      val_ff  <= val_in;
      verr_ff <= verr_in;
   end

   always_comb begin
      sts.is_digit     = (sym_ff >= CH_ZERO) && (sym_ff <= CH_NINE);
      sts.ops_empty    = (oper_cnt_ff == '0);
      sts.top_prio_ge  = prio_of(o_rd) >= prio_of(in_code);
      sts.two_operands = (opnd_cnt_ff >= CW'(2));
      sts.any_operand  = (opnd_cnt_ff != '0);
      sts.alu_done     = fin_ff;
   end

   assign out_value = val_ff;
   assign out_error = verr_ff;
endmodule

// File: sv/iee_ctrl.sv
// Controller state machine sequencing pushes, reductions and the response.
module iee_ctrl
   import iee_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_end_req,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   input  iee_sts_type sts,
   output iee_cmd_type cmd
);
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DECODE = 4'd1;
   localparam logic [3:0] S_CHECK  = 4'd2;  // operator RAM read settles
   localparam logic [3:0] S_POP    = 4'd3;
   localparam logic [3:0] S_FETCH  = 4'd4;
   localparam logic [3:0] S_FWAIT1 = 4'd5;
   localparam logic [3:0] S_FWAIT2 = 4'd6;
   localparam logic [3:0] S_ALU    = 4'd7;
   localparam logic [3:0] S_WAIT   = 4'd8;
   localparam logic [3:0] S_WRITE  = 4'd9;
   localparam logic [3:0] S_TOPRD  = 4'd10;
   localparam logic [3:0] S_TOPWT  = 4'd11;
   localparam logic [3:0] S_EMIT   = 4'd12;
   localparam logic [3:0] S_RSP    = 4'd13;

   logic [3:0] state_ff, state_in;
   logic       end_ff, end_in;
   logic       rsp_ff, rsp_in;

   always_comb begin
      state_in = state_ff;
      end_in   = end_ff;
      rsp_in   = rsp_ff;
      cmd      = '0;
      if (rsp_ff && !rsp_stall) rsp_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && !rsp_ff) begin
               cmd.load_req = 1'b1;
               end_in       = req_end_req;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            if (!end_ff && sts.is_digit) begin
               cmd.push_digit = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.ops_empty || (!end_ff && !sts.top_prio_ge)) begin
               if (end_ff) begin
                  state_in = S_TOPRD;
               end else begin
                  cmd.push_op = 1'b1;
                  state_in = S_IDLE;
               end
            end else begin
               state_in = S_POP;
            end
         end
         S_POP: begin
            cmd.pop_op = 1'b1;
            if (sts.two_operands) begin
               state_in = S_FETCH;
            end else begin
               // pass through DECODE so the new top is read back
               cmd.underflow = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_FETCH:  begin cmd.fetch = 1'b1; state_in = S_FWAIT1; end
         S_FWAIT1: state_in = S_FWAIT2;
         S_FWAIT2: state_in = S_ALU;
         S_ALU:    begin cmd.start_alu = 1'b1; state_in = S_WAIT; end
         S_WAIT:   if (sts.alu_done) state_in = S_WRITE;
         S_WRITE:  begin cmd.push_result = 1'b1; state_in = S_CHECK; end
         S_TOPRD:  state_in = S_TOPWT;
         S_TOPWT:  state_in = S_EMIT;
         S_EMIT: begin
            cmd.emit  = 1'b1;
            cmd.clear = 1'b1;
            state_in  = S_RSP;
         end
         S_RSP: begin
            rsp_in   = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         end_ff   <= 1'b0;
         rsp_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         end_ff   <= end_in;
         rsp_ff   <= rsp_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE) || rsp_ff;
   assign rsp_valid = rsp_ff;
endmodule

// File: sv/infix_expression_evaluator_core.sv
// Top level of the two-stack infix expression evaluator.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------
//   req     | in        | req_valid/req_stall  | req_symbol[7:0], req_end_req
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_value[31:0], rsp_error_code
//
// A digit is loaded, then pushed. An operator reduces while the stacked
// top has priority >= its own (pop, fetch, ALU, write-back), then is pushed;
// a nonzero divide waits on the 1-bit-per-cycle divider; underflow sets an error.
// An end request reduces all stacked operators, then emits the top operand.
// Reset is synchronous; it empties both stacks and clears the sticky error.
// No new request is taken while a response waits under rsp_stall.
module infix_expression_evaluator_core
   import iee_pkg::*;
#(
   parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [7:0]               req_symbol,
   input  logic                     req_end_req,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_value,
   output logic [ERR_W-1:0]         rsp_error_code
);
   iee_cmd_type       cmd;
   iee_sts_type       sts;
   logic [DATA_W-1:0] value;

   // sequencer: one request at a time, walks the reduction loop
   iee_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_end_req,
      .rsp_valid, .rsp_stall, .sts, .cmd);

   // stacks, ALU, divider, response registers
   iee_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
      .clock, .reset, .cmd, .sts, .req_symbol,
      .out_value(value), .out_error(rsp_error_code));

   assign rsp_value = signed'(value);
endmodule

// File: sv/iee_checker.sv
// Port-level checker for the evaluator, bound to the top level.
module iee_checker
   import iee_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              req_end_req,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [DATA_W-1:0] rsp_value,
   input logic [ERR_W-1:0]  rsp_error_code
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_value)
                                 && $stable(rsp_error_code))
      else $error("response changed under stall");

   a_no_req_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while response pending");

   a_digit_no_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !req_end_req |=> ##1 !rsp_valid)
      else $error("response without end request");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted on back-to-back cycles");
endmodule

bind infix_expression_evaluator_core iee_checker u_iee_checker (
   .clock, .reset, .req_valid, .req_stall, .req_end_req,
   .rsp_valid, .rsp_stall, .rsp_value, .rsp_error_code);
